>>> rtl/edg_pkg.sv
// ----------------------------------------------------------------------------
// edg_pkg
// Shared types and constants of the 3x3 edge gradient filter: window and
// pipeline word layouts, filter modes and configuration register indexes.
// ----------------------------------------------------------------------------
package edg_pkg;

  localparam int unsigned PIX_W      = 8;
  localparam int unsigned WIN        = 3;   // window side, one pixel of pad
  localparam int unsigned FIRST_EMIT = 2;   // first column and row with a full window
  localparam int unsigned CFG_DATA_W = 11;
  localparam int unsigned CFG_IDX_W  = 1;

  // square root datapath: sum of two 8-bit squares, 9-bit root
  localparam int unsigned SQ_REM_W   = 17;
  localparam int unsigned SQ_ROOT_W  = 9;
  localparam int unsigned SQ_TRIAL_W = 20;

  typedef logic [PIX_W-1:0] pix_t;

  localparam pix_t PIX_MAX = 8'd255;

  localparam logic [1:0] ROW_FULL = 2'd2;

  typedef enum logic [1:0] {
    MODE_PREWITT = 2'd0,
    MODE_SOBEL   = 2'd1,
    MODE_LAPLACE = 2'd2
  } filter_mode_e;

  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_MODE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PADDED_WIDTH = 1'b1;

  // window rows: 0 oldest line, 2 current line; columns: 2 newest pixel
  typedef logic [WIN-1:0][WIN-1:0][PIX_W-1:0] win_t;

  typedef struct packed {
    logic valid;
    logic last;
    win_t win;
  } win_stage_t;

  typedef struct packed {
    logic                 valid;
    logic                 lap;
    logic                 last;
    pix_t                 cx;
    pix_t                 cy;
    logic [SQ_REM_W-1:0]  rem;
    logic [SQ_ROOT_W-1:0] root;
  } sq_t;

endpackage

>>> rtl/edg_line_buffer.sv
// ----------------------------------------------------------------------------
// edg_line_buffer
// Column and row counters, two line stores and the sliding 3x3 window.
// ----------------------------------------------------------------------------
module edg_line_buffer #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  logic                            valid_i,
  input  edg_pkg::pix_t                   pixel_i,
  input  logic                            frame_start_i,
  input  logic [edg_pkg::CFG_DATA_W-1:0]  padded_width_i,
  output edg_pkg::win_stage_t             stage_o
);

  localparam int unsigned CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned LW = (CW + 1 > edg_pkg::CFG_DATA_W) ? CW + 1 : edg_pkg::CFG_DATA_W;
  localparam logic [LW-1:0] MinLast = LW'(edg_pkg::WIN - 1);
  localparam logic [LW-1:0] MaxLast = LW'(MAX_WIDTH - 1);

  logic [LW-1:0]   pw;
  logic [LW-1:0]   last_col;
  logic            acc;
  logic [CW-1:0]   col_cur;
  logic [1:0]      row_cur;
  logic            is_last;
  logic            emit;
  logic [CW-1:0]   col_q, col_d;
  logic [1:0]      row_q, row_d;

  edg_pkg::pix_t   up_mem [MAX_WIDTH];
  edg_pkg::pix_t   lo_mem [MAX_WIDTH];
  edg_pkg::pix_t   up_rd_q, lo_rd_q;

  logic            s1_valid_q;
  logic [CW-1:0]   s1_col_q;
  edg_pkg::pix_t   s1_px_q;
  logic            s1_emit_q;
  logic            s1_last_q;
  logic            hit_q;
  edg_pkg::pix_t   fwd_up_q, fwd_lo_q;
  edg_pkg::pix_t   s1_up, s1_lo;
  logic            s1_fire;

  edg_pkg::win_t   win_q;
  logic            st_valid_q;
  logic            st_last_q;

  assign pw = LW'(padded_width_i);
  always_comb begin
    priority if (pw < LW'(edg_pkg::WIN)) begin
      last_col = MinLast;
    end else if (pw > LW'(MAX_WIDTH)) begin
      last_col = MaxLast;
    end else begin
      last_col = pw - LW'(1);
    end
  end

  assign acc     = valid_i && en_i;
  assign col_cur = frame_start_i ? '0 : col_q;
  assign row_cur = frame_start_i ? '0 : row_q;
  assign is_last = LW'(col_cur) >= last_col;
  assign emit    = (row_cur == edg_pkg::ROW_FULL) && (col_cur >= CW'(edg_pkg::FIRST_EMIT));

  always_comb begin
    if (is_last) begin
      col_d = '0;
      row_d = (row_cur == edg_pkg::ROW_FULL) ? row_cur : row_cur + 2'd1;
    end else begin
      col_d = col_cur + CW'(1);
      row_d = row_cur;
    end
  end

  // a write still in flight to the column being read is forwarded
  assign s1_up   = hit_q ? fwd_up_q : up_rd_q;
  assign s1_lo   = hit_q ? fwd_lo_q : lo_rd_q;
  assign s1_fire = s1_valid_q && en_i;

  always_ff @(posedge clk_i) begin
    if (acc) begin
      up_rd_q <= up_mem[col_cur];
      lo_rd_q <= lo_mem[col_cur];
    end
    if (s1_fire) begin
      up_mem[s1_col_q] <= s1_lo;
      lo_mem[s1_col_q] <= s1_px_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_col_q  <= col_cur;
      s1_px_q   <= pixel_i;
      s1_emit_q <= emit;
      s1_last_q <= is_last;
      hit_q     <= s1_valid_q && (s1_col_q == col_cur);
      fwd_up_q  <= s1_lo;
      fwd_lo_q  <= s1_px_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
      win_q      <= '0;
      st_valid_q <= 1'b0;
      st_last_q  <= 1'b0;
    end else begin
      if (acc) begin
        col_q <= col_d;
        row_q <= row_d;
      end
      if (en_i) begin
        s1_valid_q <= acc;
        st_valid_q <= s1_valid_q && s1_emit_q;
        st_last_q  <= s1_last_q;
      end
      if (s1_fire) begin
        // advance the window one column
        for (int r = 0; r < edg_pkg::WIN; r++) begin
          for (int c = 0; c < edg_pkg::WIN - 1; c++) begin
            win_q[r][c] <= win_q[r][c+1];
          end
        end
        win_q[0][edg_pkg::WIN-1] <= s1_up;
        win_q[1][edg_pkg::WIN-1] <= s1_lo;
        win_q[2][edg_pkg::WIN-1] <= s1_px_q;
      end
    end
  end

  assign stage_o.valid = st_valid_q;
  assign stage_o.last  = st_last_q;
  assign stage_o.win   = win_q;

  a_row_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_q != 2'd3)
    else $error("row count passed saturation");

  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !en_i |=> s1_valid_q && $stable(s1_col_q) && $stable(s1_px_q))
    else $error("frozen pipeline lost its pixel");

endmodule

>>> rtl/edg_kernel.sv
// ----------------------------------------------------------------------------
// edg_kernel
// Gradient or Laplacian over the 3x3 window, clamp, then the sum of squares
// that feeds the square root cells.
// ----------------------------------------------------------------------------
module edg_kernel (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic [1:0]          mode_i,
  input  edg_pkg::win_stage_t stage_i,
  output edg_pkg::sq_t        sq_o
);

  function automatic logic signed [11:0] ext(input edg_pkg::pix_t p);
    return $signed({4'b0000, p});
  endfunction

  function automatic logic signed [11:0] wt(input edg_pkg::pix_t p, input logic dbl);
    return dbl ? (ext(p) <<< 1) : ext(p);
  endfunction

  function automatic edg_pkg::pix_t clamp(input logic signed [11:0] v);
    edg_pkg::pix_t r;
    if (v < 0) begin
      r = '0;
    end else if (v > $signed(12'(edg_pkg::PIX_MAX))) begin
      r = edg_pkg::PIX_MAX;
    end else begin
      r = v[7:0];
    end
    return r;
  endfunction

  edg_pkg::win_t          w;
  logic                   sobel;
  logic                   lap_mode;
  logic signed [11:0]     gx, gy, lap;
  edg_pkg::pix_t          cx_d, cy_d;

  logic                   s3_valid_q, s3_last_q, s3_lap_q;
  edg_pkg::pix_t          s3_cx_q, s3_cy_q;
  logic [15:0]            sqx, sqy;
  edg_pkg::sq_t           sq_q;

  assign w        = stage_i.win;
  assign sobel    = mode_i == edg_pkg::MODE_SOBEL;
  assign lap_mode = mode_i >= edg_pkg::MODE_LAPLACE;

  assign gx  = (ext(w[0][2]) + wt(w[1][2], sobel) + ext(w[2][2]))
             - (ext(w[0][0]) + wt(w[1][0], sobel) + ext(w[2][0]));
  assign gy  = (ext(w[2][0]) + wt(w[2][1], sobel) + ext(w[2][2]))
             - (ext(w[0][0]) + wt(w[0][1], sobel) + ext(w[0][2]));
  assign lap = ext(w[0][1]) + ext(w[2][1]) + ext(w[1][0]) + ext(w[1][2])
             - (ext(w[1][1]) <<< 2);

  assign cx_d = lap_mode ? clamp(lap) : clamp(gx);
  assign cy_d = lap_mode ? '0 : clamp(gy);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s3_last_q <= stage_i.last;
      s3_lap_q  <= lap_mode;
      s3_cx_q   <= cx_d;
      s3_cy_q   <= cy_d;
    end
  end

  assign sqx = 16'(s3_cx_q) * 16'(s3_cx_q);
  assign sqy = 16'(s3_cy_q) * 16'(s3_cy_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
      sq_q       <= '0;
    end else if (en_i) begin
      s3_valid_q <= stage_i.valid;
      sq_q.valid <= s3_valid_q;
      sq_q.lap   <= s3_lap_q;
      sq_q.last  <= s3_last_q;
      sq_q.cx    <= s3_cx_q;
      sq_q.cy    <= s3_cy_q;
      sq_q.rem   <= edg_pkg::SQ_REM_W'(sqx) + edg_pkg::SQ_REM_W'(sqy);
      sq_q.root  <= '0;
    end
  end

  assign sq_o = sq_q;

endmodule

>>> rtl/edg_sqrt_cell.sv
// ----------------------------------------------------------------------------
// edg_sqrt_cell
// One digit of a restoring square root: tries root bit K against the
// remainder and hands the word to the next cell.
// ----------------------------------------------------------------------------
module edg_sqrt_cell #(
  parameter int unsigned K = 0
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  edg_pkg::sq_t cell_i,
  output edg_pkg::sq_t cell_o
);

  localparam int unsigned TW = edg_pkg::SQ_TRIAL_W;

  logic [TW-1:0] trial;
  logic          take;
  edg_pkg::sq_t  nxt;
  edg_pkg::sq_t  cell_q;

  // (2*root + 2^K) * 2^K; root holds only bits above K
  assign trial = (TW'(cell_i.root) << (K + 1)) | (TW'(1) << (2 * K));
  assign take  = trial <= TW'(cell_i.rem);

  always_comb begin
    nxt = cell_i;
    if (take) begin
      nxt.rem  = cell_i.rem - edg_pkg::SQ_REM_W'(trial);
      nxt.root = cell_i.root | (edg_pkg::SQ_ROOT_W'(1) << K);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else if (en_i) begin
      cell_q <= nxt;
    end
  end

  assign cell_o = cell_q;

endmodule

>>> rtl/edge_gradient_3x3_filter_core.sv
// ----------------------------------------------------------------------------
// edge_gradient_3x3_filter_core
// 3x3 Prewitt / Sobel gradient magnitude or Laplacian over a padded raster
// pixel stream.
// ----------------------------------------------------------------------------
// Takes one pixel per cycle and, once two full rows are in, gives one result
// per pixel from the third pixel of each row on; each result belongs to
// the window that ends at the pixel just taken. The pipeline is 14 stages
// deep: line store read and window shift, kernel, clamp and squares, then a
// chain of nine square root cells that each settle one root bit, and the
// output register. The line stores are read and written once per pixel, so
// one pixel per cycle is the sustained rate. A stalled result holds the
// whole pipeline, so input stalls while the output register is full and
// stalled. Write filter_mode and padded_width only while no pixel is in
// flight; frame_start restarts row and column counting.
// ----------------------------------------------------------------------------
module edge_gradient_3x3_filter_core #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [7:0]                     pixel_i,
  input  logic                           frame_start_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [7:0]                     result_pixel_o,
  output logic [7:0]                     grad_x_o,
  output logic [7:0]                     grad_y_o,
  output logic                           row_end_o,
  input  logic                           cfg_we_i,
  input  logic [edg_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [edg_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned CELLS = edg_pkg::SQ_ROOT_W;

  logic [1:0]                      mode_q;
  logic [edg_pkg::CFG_DATA_W-1:0]  width_q;
  logic                            adv;
  edg_pkg::win_stage_t             stage;
  edg_pkg::sq_t                    chain [CELLS+1];
  edg_pkg::sq_t                    tail;
  edg_pkg::pix_t                   root_sat;

  logic                            out_valid_q;
  logic                            row_end_q;
  edg_pkg::pix_t                   result_q, gx_q, gy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= edg_pkg::MODE_SOBEL;
      width_q <= edg_pkg::CFG_DATA_W'(1024);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        edg_pkg::CFG_FILTER_MODE:  mode_q  <= cfg_data_i[1:0];
        edg_pkg::CFG_PADDED_WIDTH: width_q <= cfg_data_i;
        default:                   mode_q  <= mode_q;
      endcase
    end
  end

  // whole pipeline moves only when the output register can take a word
  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = !adv;

  edg_line_buffer #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line_buffer (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .en_i           (adv),
    .valid_i        (in_valid_i),
    .pixel_i        (pixel_i),
    .frame_start_i  (frame_start_i),
    .padded_width_i (width_q),
    .stage_o        (stage)
  );

  edg_kernel u_kernel (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .mode_i  (mode_q),
    .stage_i (stage),
    .sq_o    (chain[0])
  );

  for (genvar i = 0; i < CELLS; i++) begin : g_cell
    edg_sqrt_cell #(
      .K (CELLS - 1 - i)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .cell_i (chain[i]),
      .cell_o (chain[i+1])
    );
  end

  assign tail     = chain[CELLS];
  assign root_sat = (tail.root > edg_pkg::SQ_ROOT_W'(edg_pkg::PIX_MAX))
                    ? edg_pkg::PIX_MAX : tail.root[7:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= tail.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      result_q  <= tail.lap ? tail.cx : root_sat;
      gx_q      <= tail.cx;
      gy_q      <= tail.cy;
      row_end_q <= tail.last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_pixel_o = result_q;
  assign grad_x_o       = gx_q;
  assign grad_y_o       = gy_q;
  assign row_end_o      = row_end_q;

  a_lap_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (mode_q >= edg_pkg::MODE_LAPLACE)
      |-> (grad_y_o == '0) && (result_pixel_o == grad_x_o))
    else $error("Laplacian result and gradient fields disagree");

  a_mag_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (mode_q < edg_pkg::MODE_LAPLACE)
      |-> (result_pixel_o >= grad_x_o) && (result_pixel_o >= grad_y_o))
    else $error("gradient magnitude below one of its components");

  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(tail.valid) && $past(adv))
    else $error("result appeared without a word leaving the root chain");

endmodule
